/* rtl/core/btc_pkg.sv */
// Package for the breakpoint table converter.
// Holds item kinds, status codes, register addresses and shared types.
// No dependencies.
package btc_pkg;

	localparam int TableDepthDef = 64;
	localparam int FracBitsDef = 16;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_FWD = 2'd1;
	localparam logic [1:0] KIND_REV = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EXTRAP = 2'd1;
	localparam logic [1:0] ST_ZERO_SLOPE = 2'd2;

	localparam logic [0:0] REG_ENTRY_COUNT = 1'd0;
	localparam logic [6:0] ENTRY_COUNT_RESET = 7'd2;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch input item, start at p0
		logic rd;        // issue table read at p
		logic inc;       // p <= p + 1
		logic dec;       // p <= p - 1
		logic mul_go;    // start forward product
		logic div_go;    // start reverse divide
		logic div_step;  // one divider step
		logic fin;       // form result register
	} btc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rev;       // reverse conversion
		logic rising;    // key rises over start segment
		logic v_gt_hi;   // v > key[p+1]
		logic v_le_hi;   // v <= key[p+1]
		logic v_lt_lo;   // v < key[p]
		logic v_gt_lo;   // v > key[p]
		logic at_top;    // p == n-2
		logic at_zero;   // p == 0
		logic zero_slope;
		logic div_done;
	} btc_sts_t;

endpackage

/* rtl/core/btc_ctrl.sv */
// Controller for the breakpoint table converter.
// Sequences table reads, the segment walk and the arithmetic. Uses btc_pkg.
module btc_ctrl import btc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  btc_sts_t sts,
	output btc_cmd_t cmd,
	output logic     busy,
	output logic     set_extrap,
	output logic     done
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD0 = 4'd1;  // read start segment pair
	localparam logic [3:0] S_DIR = 4'd2;  // pick direction
	localparam logic [3:0] S_UP = 4'd3;
	localparam logic [3:0] S_UPRD = 4'd4;
	localparam logic [3:0] S_DN = 4'd5;
	localparam logic [3:0] S_DNRD = 4'd6;
	localparam logic [3:0] S_CALC = 4'd7;
	localparam logic [3:0] S_MUL = 4'd8;
	localparam logic [3:0] S_DIV = 4'd9;
	localparam logic [3:0] S_FIN = 4'd10;
	localparam logic [3:0] S_DIVGO = 4'd11;  // load divider from fresh read

	logic [3:0] state_q, state_d;
	logic rising_q, rising_d;

	always_comb begin
		state_d = state_q;
		rising_d = rising_q;
		cmd = '0;
		set_extrap = 1'b0;
		done = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_RD0;
				end
			end
			S_RD0: begin
				cmd.rd = 1'b1;
				state_d = S_DIR;
			end
			S_DIR: begin
				rising_d = sts.rising;
				state_d = S_UP;
			end
			S_UP: begin
				// climb while the value lies beyond the upper key
				if (rising_q ? sts.v_gt_hi : sts.v_le_hi) begin
					if (sts.at_top) begin
						cmd.inc = 1'b1;
						set_extrap = 1'b1;
						state_d = S_CALC;
					end else begin
						cmd.inc = 1'b1;
						state_d = S_UPRD;
					end
				end else begin
					state_d = S_DN;
				end
			end
			S_UPRD: begin
				cmd.rd = 1'b1;
				state_d = S_UP;
			end
			S_DN: begin
				if (rising_q ? sts.v_lt_lo : sts.v_gt_lo) begin
					if (sts.at_zero) begin
						set_extrap = 1'b1;
						state_d = S_CALC;
					end else begin
						cmd.dec = 1'b1;
						state_d = S_DNRD;
					end
				end else begin
					state_d = S_CALC;
				end
			end
			S_DNRD: begin
				cmd.rd = 1'b1;
				state_d = S_DN;
			end
			S_CALC: begin
				cmd.rd = 1'b1;
				state_d = sts.rev ? S_DIVGO : S_MUL;
			end
			S_MUL: begin
				cmd.mul_go = 1'b1;
				state_d = S_FIN;
			end
			S_DIVGO: begin
				cmd.div_go = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (sts.zero_slope) begin
					state_d = S_FIN;
				end else begin
					cmd.div_step = 1'b1;
					if (sts.div_done) state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rising_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rising_q <= rising_d;
		end
	end

endmodule

/* rtl/core/btc_datapath.sv */
// Datapath for the breakpoint table converter: table memories, segment
// pointer, key compares, multiplier and restoring divider. Uses btc_pkg.
module btc_datapath import btc_pkg::*; #(
	parameter int TABLE_DEPTH = TableDepthDef,
	parameter int FRAC_BITS = FracBitsDef,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  btc_cmd_t           cmd,
	output btc_sts_t           sts,
	input  logic               wr_en,
	input  logic [5:0]         wr_index,
	input  logic signed [31:0] wr_raw,
	input  logic signed [31:0] wr_eng,
	input  logic signed [31:0] wr_slope,
	input  logic [1:0]         kind,
	input  logic signed [31:0] in_value,
	input  logic               restart,
	input  logic [6:0]         entry_count,
	input  logic               set_extrap,
	output logic signed [31:0] res_value,
	output logic [1:0]         res_status,
	output logic [5:0]         res_segment
);

	localparam int DW = 33 + FRAC_BITS;  // dividend magnitude width
	localparam int DCW = $clog2(DW + 1);

	logic [31:0] raw_mem [TABLE_DEPTH];
	logic [31:0] eng_mem [TABLE_DEPTH];
	logic [31:0] slope_mem [TABLE_DEPTH];

	logic [AW-1:0] last_q, p_q;
	logic [AW-1:0] nm2;
	logic signed [31:0] v_q;
	logic rev_q, ext_q;
	logic signed [31:0] lo_raw_q, lo_eng_q, hi_key_q, slope_q;
	logic signed [31:0] lo_key;

	// clamp entry count to 2..TABLE_DEPTH, then n-2
	logic [CW-1:0] n_c;
	always_comb begin
		if (entry_count < 7'd2) n_c = CW'(2);
		else if ({25'd0, entry_count} > 32'(TABLE_DEPTH)) n_c = CW'(TABLE_DEPTH);
		else n_c = CW'(entry_count);
		nm2 = AW'(n_c - CW'(2));
	end

	logic [AW-1:0] p0;
	always_comb begin
		p0 = restart ? '0 : last_q;
		if (p0 > nm2) p0 = nm2;
	end

	always_ff @(posedge clk) begin
		if (wr_en && {26'd0, wr_index} < 32'(TABLE_DEPTH)) begin
			raw_mem[AW'(wr_index)] <= wr_raw;
			eng_mem[AW'(wr_index)] <= wr_eng;
			slope_mem[AW'(wr_index)] <= wr_slope;
		end
	end

	// registered reads of entry p and p+1 (p+1 wraps only when past top)
	logic [AW-1:0] p_hi;
	assign p_hi = p_q + AW'(1);
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			lo_raw_q <= raw_mem[p_q];
			lo_eng_q <= eng_mem[p_q];
			slope_q <= slope_mem[p_q];
			hi_key_q <= rev_q ? eng_mem[p_hi] : raw_mem[p_hi];
		end
	end
	assign lo_key = rev_q ? lo_eng_q : lo_raw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			p_q <= '0;
			rev_q <= 1'b0;
			ext_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				p_q <= p0;
				rev_q <= (kind == KIND_REV);
				ext_q <= 1'b0;
			end else if (cmd.inc) begin
				p_q <= p_q + AW'(1);
			end else if (cmd.dec) begin
				p_q <= p_q - AW'(1);
			end
			if (set_extrap) ext_q <= 1'b1;
			if (cmd.fin) last_q <= p_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) v_q <= in_value;
	end

	assign sts.rev = rev_q;
	assign sts.rising = hi_key_q > lo_key;
	assign sts.v_gt_hi = v_q > hi_key_q;
	assign sts.v_le_hi = v_q <= hi_key_q;
	assign sts.v_lt_lo = v_q < lo_key;
	assign sts.v_gt_lo = v_q > lo_key;
	assign sts.at_top = (p_q == nm2);
	assign sts.at_zero = (p_q == '0);
	assign sts.zero_slope = (slope_q == '0);

	// difference, exact in 33 bits
	logic signed [32:0] diff;
	assign diff = 33'(v_q) - 33'(lo_key);

	// forward: diff * slope, registered
	logic signed [64:0] prod_s1;
	always_ff @(posedge clk) begin
		if (cmd.mul_go) prod_s1 <= 65'(diff) * 65'(slope_q);
	end

	// reverse: restoring divide on magnitudes, one bit a cycle
	logic [DW-1:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic neg_q, dpos_q, dzero_q;
	logic [DCW-1:0] cnt_q;
	logic [33:0] trial;
	logic [32:0] dmag;

	assign dmag = diff[32] ? 33'(-diff) : 33'(diff);
	assign trial = {rem_q, quo_q[DW-1]} - {2'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_go) begin
			quo_q <= {dmag, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			dvs_q <= slope_q[31] ? 32'(-slope_q) : 32'(slope_q);
			neg_q <= diff[32] ^ slope_q[31];
			dpos_q <= !diff[32] && (diff != '0);
			dzero_q <= (diff == '0);
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
			cnt_q <= cnt_q + DCW'(1);
		end
	end
	assign sts.div_done = (cnt_q == DCW'(DW - 1));

	// result: add base and saturate
	logic signed [66:0] sum;
	logic signed [31:0] sat;
	always_comb begin
		if (rev_q) begin
			sum = 67'(signed'({1'b0, quo_q}));
			if (neg_q) sum = -sum;
			sum = sum + 67'(lo_raw_q);
		end else begin
			sum = 67'(prod_s1 >>> FRAC_BITS) + 67'(lo_eng_q);
		end
		if (sum > 67'sd2147483647) sat = 32'sh7fffffff;
		else if (sum < -67'sd2147483648) sat = 32'sh80000000;
		else sat = sum[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			res_segment <= 6'(p_q);
			if (rev_q && slope_q == '0) begin
				res_status <= ST_ZERO_SLOPE;
				res_value <= dpos_q ? 32'sh7fffffff :
					(dzero_q ? lo_raw_q : 32'sh80000000);
			end else begin
				res_status <= ext_q ? ST_EXTRAP : ST_OK;
				res_value <= sat;
			end
		end
	end

endmodule

/* rtl/core/breakpoint_table_converter.sv */
// Breakpoint table converter: piecewise linear Q16.16 lookup between raw and
// engineering values. Top level; instantiates btc_ctrl and btc_datapath.
//
// A convert request keeps the converter busy through the start segment read,
// a walk from the last used segment (segment 0 on restart), each step a
// pointer move and a table read, and the arithmetic; the step past the top
// end issues no extra read. A reverse conversion runs the one-bit-a-cycle
// divider for 33+FRAC_BITS quotient bits (49), or skips the divide steps when
// the slope is zero. One request is worked on at a time; a finished result
// waits in the output register, and the next request is taken once it leaves.
// Write requests are kind 0. Table entries never written read as undefined.
module breakpoint_table_converter import btc_pkg::*; #(
	parameter int TABLE_DEPTH = TableDepthDef,
	parameter int FRAC_BITS = FracBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [5:0]         entry_index,
	input  logic signed [31:0] entry_raw,
	input  logic signed [31:0] entry_eng,
	input  logic signed [31:0] entry_slope,
	input  logic signed [31:0] in_value,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_value,
	output logic [1:0]         status,
	output logic [5:0]         segment
);

	logic [6:0] entry_count_q;
	btc_cmd_t cmd;
	btc_sts_t sts;
	logic busy, done, set_extrap, start, accept;
	logic signed [31:0] res_value;
	logic [1:0] res_status;
	logic [5:0] res_segment;
	logic out_valid_q;

	assign pready = 1'b1;
	assign prdata = (paddr[1:0] == {REG_ENTRY_COUNT, 1'b0}) ? {25'd0, entry_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= ENTRY_COUNT_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == {REG_ENTRY_COUNT, 1'b0}) begin
			entry_count_q <= pwdata[6:0];
		end
	end

	// hold off while converting or while a result still waits at the output
	assign in_ready = !busy && !(out_valid_q && !out_ready);
	assign accept = in_valid && in_ready;
	assign start = accept && (kind == KIND_FWD || kind == KIND_REV);

	btc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy),
		.set_extrap (set_extrap),
		.done       (done)
	);

	btc_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.wr_en       (accept && kind == KIND_WRITE),
		.wr_index    (entry_index),
		.wr_raw      (entry_raw),
		.wr_eng      (entry_eng),
		.wr_slope    (entry_slope),
		.kind        (kind),
		.in_value    (in_value),
		.restart     (restart),
		.entry_count (entry_count_q),
		.set_extrap  (set_extrap),
		.res_value   (res_value),
		.res_status  (res_status),
		.res_segment (res_segment)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = res_value;
	assign status = res_status;
	assign segment = res_segment;

endmodule

/* sim/breakpoint_table_converter_tb.sv */
// Testbench for breakpoint_table_converter: loads breakpoint tables, sends
// forward and reverse conversions and checks every result against a predictor.
// Depends on btc_pkg and the RTL of the converter only.
`timescale 1ns / 100ps

module breakpoint_table_converter_tb;
	import btc_pkg::*;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         st;
		logic [5:0]         seg;
	} conv_result_t;

	// Predicts each conversion from its own copy of the table and compares.
	class conv_scoreboard;
		logic signed [31:0] raw_tab [64];
		logic signed [31:0] eng_tab [64];
		logic signed [31:0] slope_tab [64];
		logic [6:0]         count_reg;
		logic [5:0]         last_seg;
		conv_result_t       pending [$];
		int                 errors;

		function new();
			count_reg = ENTRY_COUNT_RESET;
			last_seg = '0;
			errors = 0;
		endfunction

		function int used_entries();
			if (count_reg < 2)
				return 2;
			if (count_reg > 64)
				return 64;
			return count_reg;
		endfunction

		function longint key_at(bit rev, int i);
			return rev ? longint'(eng_tab[i]) : longint'(raw_tab[i]);
		endfunction

		task flag_mismatch(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void note_request(logic [1:0] kind, logic [5:0] idx,
				logic signed [31:0] r, logic signed [31:0] e, logic signed [31:0] s,
				logic signed [31:0] x, logic rst);
			int n, p;
			bit rev;
			longint v, d, res, sl;
			conv_result_t exp_res;
			exp_res.st = ST_OK;
			if (kind == KIND_WRITE) begin
				raw_tab[idx] = r;
				eng_tab[idx] = e;
				slope_tab[idx] = s;
				return;
			end
			if (kind != KIND_FWD && kind != KIND_REV)
				return;
			rev = (kind == KIND_REV);
			n = used_entries();
			p = rst ? 0 : int'(last_seg);
			if (p > n - 2)
				p = n - 2;
			v = longint'(x);
			// walk up then down; direction follows the start segment
			if (key_at(rev, p + 1) > key_at(rev, p)) begin
				while (v > key_at(rev, p + 1)) begin
					p++;
					if (p > n - 2) begin
						exp_res.st = ST_EXTRAP;
						break;
					end
				end
				while (v < key_at(rev, p)) begin
					if (p == 0) begin
						exp_res.st = ST_EXTRAP;
						break;
					end
					p--;
				end
			end else begin
				while (v <= key_at(rev, p + 1)) begin
					p++;
					if (p > n - 2) begin
						exp_res.st = ST_EXTRAP;
						break;
					end
				end
				while (v > key_at(rev, p)) begin
					if (p == 0) begin
						exp_res.st = ST_EXTRAP;
						break;
					end
					p--;
				end
			end
			d = v - key_at(rev, p);
			sl = longint'(slope_tab[p]);
			if (!rev)
				res = longint'(eng_tab[p]) + ((d * sl) >>> 16);
			else if (sl == 0) begin
				exp_res.st = ST_ZERO_SLOPE;
				if (d > 0)
					res = 64'sd2147483647;
				else if (d < 0)
					res = -64'sd2147483648;
				else
					res = longint'(raw_tab[p]);
			end else
				res = longint'(raw_tab[p]) + (d * 64'sd65536) / sl;
			if (res > 64'sd2147483647)
				res = 64'sd2147483647;
			if (res < -64'sd2147483648)
				res = -64'sd2147483648;
			last_seg = p[5:0];
			exp_res.value = res[31:0];
			exp_res.seg = p[5:0];
			pending.push_back(exp_res);
		endfunction

		task check_result(logic signed [31:0] v, logic [1:0] st, logic [5:0] seg);
			conv_result_t w;
			if (pending.size() == 0) begin
				flag_mismatch("result with nothing expected");
				return;
			end
			w = pending.pop_front();
			if (v !== w.value)
				flag_mismatch($sformatf("out_value %h, want %h", v, w.value));
			if (st !== w.st)
				flag_mismatch($sformatf("status %0d, want %0d", st, w.st));
			if (seg !== w.seg)
				flag_mismatch($sformatf("segment %0d, want %0d", seg, w.seg));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [1:0] kind;
	logic [5:0] entry_index;
	logic signed [31:0] entry_raw, entry_eng, entry_slope, in_value;
	logic restart;
	logic out_valid, out_ready;
	logic signed [31:0] out_value;
	logic [1:0] status;
	logic [5:0] segment;

	conv_scoreboard sb = new();
	bit calm;
	int sent;
	int stalled;

	breakpoint_table_converter i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.entry_index(entry_index), .entry_raw(entry_raw), .entry_eng(entry_eng),
		.entry_slope(entry_slope), .in_value(in_value), .restart(restart),
		.out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
		.status(status), .segment(segment)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 37);
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(out_value, status, segment);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			stalled <= 0;
		else
			stalled <= stalled + 1;
		if (stalled == 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task send(logic [1:0] k, logic [5:0] idx, logic signed [31:0] r,
			logic signed [31:0] e, logic signed [31:0] s, logic signed [31:0] x,
			logic rst);
		if (!calm && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 3))
				@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		entry_index <= idx;
		entry_raw <= r;
		entry_eng <= e;
		entry_slope <= s;
		in_value <= x;
		restart <= rst;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(k, idx, r, e, s, x, rst);
		sent++;
	endtask

	task convert(logic [1:0] k, logic signed [31:0] x, logic rst);
		send(k, 6'($urandom), $urandom, $urandom, $urandom, x, rst);
	endtask

	// wait out pending results plus the longest possible walk and divide
	task drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task write_count(logic [6:0] cnt);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 2'(4 * REG_ENTRY_COUNT);
		pwdata <= {25'($urandom), cnt};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.count_reg = cnt;
		@(posedge clk);
	endtask

	// value near the active table most of the time, else anywhere
	function logic signed [31:0] pick_value(bit rev);
		int n, i;
		longint k;
		n = sb.used_entries();
		i = $urandom_range(0, n - 1);
		k = sb.key_at(rev, i);
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return ($urandom_range(0, 1)) ? 32'sh7FFFFFFF : 32'sh80000000;
			3: return k[31:0];
			4: return k[31:0] + 1;
			default: begin
				k = k + $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh0001FFFF;
				if (k > 64'sd2147483647 || k < -64'sd2147483648)
					return k[31:0] ^ 32'h80000000;
				return k[31:0];
			end
		endcase
	endfunction

	task load_table(int n);
		longint rk, ek, sm;
		bit rf, ef, noisy;
		logic signed [31:0] sl;
		noisy = ($urandom_range(0, 4) == 0);
		rf = 1'($urandom_range(0, 1));
		ef = 1'($urandom_range(0, 1));
		sm = ($urandom_range(0, 2) == 0) ? 16 : 32'h01FFFFFF;
		rk = -64'sd2147483647 + $urandom_range(0, 32'h3FFFFFFF);
		ek = -64'sd2147483647 + $urandom_range(0, 32'h3FFFFFFF);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: sl = '0;
				1: sl = $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh0001FFFF;
				default: sl = $urandom;
			endcase
			if (noisy)
				send(KIND_WRITE, i[5:0], $urandom, $urandom, sl, $urandom,
					1'($urandom));
			else
				send(KIND_WRITE, i[5:0], rf ? -rk : rk, ef ? -ek : ek, sl,
					$urandom, 1'($urandom));
			if ($urandom_range(0, 19) != 0)
				rk += $urandom_range(1, sm);
			if ($urandom_range(0, 19) != 0)
				ek += $urandom_range(1, sm);
		end
	endtask

	initial begin
		logic [6:0] cnt;
		int n, phase;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		kind = KIND_WRITE;
		entry_index = '0;
		entry_raw = '0;
		entry_eng = '0;
		entry_slope = '0;
		in_value = '0;
		restart = 1'b0;
		out_ready = 1'b0;
		calm = 1'b0;
		sent = 0;
		stalled = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rising table: slope 2.0, zero slopes at entries 0 and 5
		for (int i = 0; i < 64; i++)
			send(KIND_WRITE, i[5:0], i * 32'sh10000, i * 32'sh20000,
				(i == 0 || i == 5) ? 32'sh0 : 32'sh20000, $urandom, i[0]);
		convert(KIND_FWD, 32'sh8000, 1'b0);
		convert(KIND_FWD, 32'sh7FFFFFFF, 1'b0);
		convert(KIND_FWD, 32'sh80000000, 1'b0);
		convert(KIND_REV, 32'sh10000, 1'b1);
		convert(2'd3, 32'sh10000, 1'b0);
		write_count(7'd64);
		convert(KIND_FWD, 32'sh7FFFFFFF, 1'b0);
		convert(KIND_REV, 32'sh7FFFFFFF, 1'b0);
		convert(KIND_REV, 32'sh80000000, 1'b1);
		convert(KIND_REV, 5 * 32'sh20000 + 32'sh10000, 1'b1);
		convert(KIND_REV, 5 * 32'sh20000, 1'b0);
		convert(KIND_FWD, 32'sh3F0000, 1'b0);
		// segment left high by the last item is clamped to the smaller table
		write_count(7'd3);
		convert(KIND_FWD, 32'sh18000, 1'b0);
		write_count(7'd0);
		convert(KIND_REV, 32'sh30000, 1'b0);
		write_count(7'd127);
		convert(KIND_FWD, 32'sh3E8000, 1'b1);

		phase = 0;
		while (sent < 900) begin
			case (phase % 6)
				0: cnt = 7'd2;
				1: cnt = 7'd64;
				2: cnt = 7'($urandom_range(65, 127));
				3: cnt = 7'($urandom_range(0, 1));
				default: cnt = 7'($urandom_range(2, 64));
			endcase
			write_count(cnt);
			n = sb.used_entries();
			load_table(n);
			calm = (phase == 4);
			repeat ($urandom_range(40, 90)) begin
				case ($urandom_range(0, 29))
					0: send(KIND_WRITE, 6'($urandom_range(0, 63)), $urandom, $urandom,
						$urandom, $urandom, 1'($urandom));
					1: send(2'd3, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
						1'($urandom));
					default: begin
						kind_pick: begin
							bit rv;
							rv = 1'($urandom_range(0, 1));
							convert(rv ? KIND_REV : KIND_FWD, pick_value(rv),
								$urandom_range(0, 4) == 0);
						end
					end
				endcase
			end
			calm = 1'b0;
			phase++;
		end

		drain();
		if (sb.pending.size() != 0)
			sb.flag_mismatch("expected results never arrived");
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
